/* design/mvds_pkg.sv */
package mvds_pkg;

    // digit count and derived widths
    localparam int DIGIT_COUNT = 9;
    localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int SHOWN_W     = 4;
    localparam int WORD_W      = 18;
    localparam int FRAME_W     = 17;
    localparam int SEG_W       = 8;
    localparam int GRID_W      = 9;
    localparam int LIMIT_W     = 6;

    localparam int DP_BIT    = 6;
    localparam int BLINK_BIT = 17;

    localparam logic [FRAME_W-1:0] BLANK_KEEP  = 17'h1FF40;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd9;

    localparam logic [7:0] ASCII_BASE  = 8'h2D;
    localparam int         ASCII_LEN   = 46;
    localparam int         SPECIAL_LEN = 10;

    // command codes
    localparam logic [3:0] FUNC_SCAN      = 4'd0;
    localparam logic [3:0] FUNC_WR_CHAR   = 4'd1;
    localparam logic [3:0] FUNC_SET_DP    = 4'd2;
    localparam logic [3:0] FUNC_CLR_DP    = 4'd3;
    localparam logic [3:0] FUNC_SET_BLINK = 4'd4;
    localparam logic [3:0] FUNC_CLR_BLINK = 4'd5;
    localparam logic [3:0] FUNC_CLR_ALL   = 4'd6;
    localparam logic [3:0] FUNC_CLR_DIGIT = 4'd7;
    localparam logic [3:0] FUNC_SHOW      = 4'd8;

    // grid select per digit position, digits past the ninth have no grid
    localparam logic [GRID_W-1:0] GRID_CODES [16] = '{
        9'h100, 9'h010, 9'h008, 9'h004, 9'h020, 9'h002, 9'h040, 9'h001, 9'h080,
        9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000
    };

    localparam logic [SEG_W-1:0] SPECIAL_GLYPHS [SPECIAL_LEN] = '{
        8'h00, 8'h87, 8'h82, 8'h06, 8'h0C, 8'h28, 8'h30, 8'h14, 8'h05, 8'h81
    };

    localparam logic [SEG_W-1:0] ASCII_GLYPHS [ASCII_LEN] = '{
        8'h04, 8'h00, 8'h00, 8'hBB, 8'h12, 8'hAE, 8'hB6, 8'h17, 8'hB5, 8'hBD,
        8'h93, 8'hBF, 8'hB7, 8'h00, 8'h00, 8'h28, 8'h24, 8'h30, 8'h00, 8'h00,
        8'h9F, 8'h3D, 8'hA9, 8'h3E, 8'hAD, 8'h8D, 8'hB9, 8'h1F, 8'h09, 8'h32,
        8'h00, 8'h29, 8'h15, 8'h9B, 8'h3C, 8'h8F, 8'h00, 8'h0C, 8'hB5, 8'h2D,
        8'h3B, 8'h70, 8'h0E, 8'h00, 8'h0F, 8'h00
    };

    typedef struct packed {
        logic             ok;
        logic [SEG_W-1:0] seg;
    } glyph_t;

    // per-request update to the digit store, already qualified by the handshake
    typedef struct packed {
        logic             wr_char;
        logic             set_dp;
        logic             clr_dp;
        logic             set_blink;
        logic             clr_blink;
        logic             clr_all;
        logic             clr_digit;
        logic [IDX_W-1:0] idx;
        glyph_t           glyph;
    } store_cmd_t;

    function automatic logic [GRID_W-1:0] grid_code(input logic [3:0] pos);
        return GRID_CODES[pos];
    endfunction

    function automatic glyph_t glyph_lookup(input logic [7:0] code,
                                            input logic [LIMIT_W-1:0] limit);
        glyph_t     g;
        logic [7:0] k;
        g.ok  = 1'b1;
        g.seg = '0;
        k     = '0;
        if (code >= ASCII_BASE)
        begin
            k = code - ASCII_BASE;
            if (k >= 8'(ASCII_LEN))
            begin
                k = 8'(ASCII_LEN - 1);
            end
            g.seg = ASCII_GLYPHS[k[5:0]];
        end
        else if (code <= {2'b00, limit})
        begin
            k = code;
            if (k >= 8'(SPECIAL_LEN))
            begin
                k = 8'(SPECIAL_LEN - 1);
            end
            g.seg = SPECIAL_GLYPHS[k[3:0]];
        end
        else
        begin
            g.ok = 1'b0;
        end
        return g;
    endfunction

endpackage

/* design/mvds_digit_store.sv */
module mvds_digit_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mvds_pkg::store_cmd_t           cmd,
    input  logic [mvds_pkg::IDX_W-1:0]     rd_addr,
    output logic [mvds_pkg::WORD_W-1:0]    rd_word
);
    import mvds_pkg::*;

    logic [WORD_W-1:0] word_reg  [DIGIT_COUNT];
    logic [WORD_W-1:0] word_next [DIGIT_COUNT];

    // one update cell per digit, each only touches its own word
    for (genvar i = 0; i < DIGIT_COUNT; i++)
    begin : g_cell
        localparam logic [IDX_W-1:0] CELL_IDX = IDX_W'(i);
        logic              sel;
        logic [WORD_W-1:0] grid_word;

        assign sel       = (cmd.idx == CELL_IDX);
        assign grid_word = {1'b0, grid_code(4'(i)), {SEG_W{1'b0}}};

        always_comb
        begin
            word_next[i] = word_reg[i];
            if (cmd.clr_all || (cmd.clr_digit && sel))
            begin
                word_next[i] = grid_word;
            end
            else if (sel)
            begin
                if (cmd.wr_char && cmd.glyph.ok)
                begin
                    // glyph replaces grid and segments, old dp and blink kept
                    word_next[i]            = grid_word | {10'b0, cmd.glyph.seg};
                    word_next[i][DP_BIT]    = cmd.glyph.seg[DP_BIT] | word_reg[i][DP_BIT];
                    word_next[i][BLINK_BIT] = word_reg[i][BLINK_BIT];
                end
                if (cmd.set_dp)
                begin
                    word_next[i][DP_BIT] = 1'b1;
                end
                if (cmd.clr_dp)
                begin
                    word_next[i][DP_BIT] = 1'b0;
                end
                if (cmd.set_blink)
                begin
                    word_next[i][BLINK_BIT] = 1'b1;
                end
                if (cmd.clr_blink)
                begin
                    word_next[i][BLINK_BIT] = 1'b0;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                word_reg[i] <= '0;
            end
            else
            begin
                word_reg[i] <= word_next[i];
            end
        end
    end

    assign rd_word = word_reg[rd_addr];

endmodule

/* design/mvds_scan_ctrl.sv */
module mvds_scan_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    output logic [mvds_pkg::IDX_W-1:0]  scan_pos,
    output logic                        blank_phase
);
    import mvds_pkg::*;

    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(DIGIT_COUNT - 1);

    logic [IDX_W-1:0] pos_reg;
    logic [IDX_W-1:0] pos_next;
    logic [6:0]       phase_reg;
    logic [6:0]       phase_next;

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        if (advance)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            // phase steps once per full sweep, when the last digit comes up
            if (pos_next == LAST_POS)
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    assign scan_pos    = pos_reg;
    assign blank_phase = phase_reg[6];

endmodule

/* design/multiplexed_vfd_digit_scanner.sv */
// path: a taken request is held in the input register, then moves into the result
// register once the result register has room; until then in_stall holds off new ones
// throughput: one request per cycle while in_stall is low, a scan tick or show digit
// gives one result, all other requests give none
// reset: asynchronous active low, clears digit words, scan position, blink phase,
// both pipeline valids, and loads the special code limit with 9
module multiplexed_vfd_digit_scanner (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [3:0]                          func,
    input  logic [7:0]                          digit_index,
    input  logic [7:0]                          char_code,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [mvds_pkg::FRAME_W-1:0]        frame,
    output logic [mvds_pkg::SHOWN_W-1:0]        shown_digit,
    // special code limit register
    input  logic                                cfg_we,
    input  logic [mvds_pkg::LIMIT_W-1:0]        cfg_wdata
);
    import mvds_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

    // config register
    logic [LIMIT_W-1:0] limit_reg;

    // input register
    logic             req_valid_reg;
    logic [3:0]       func_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0]       code_reg;
    logic             req_load;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [FRAME_W-1:0] frame_reg;
    logic [SHOWN_W-1:0] shown_reg;

    // processing stage
    logic              out_free;
    logic              proceed;
    logic              is_scan;
    logic              is_show;
    store_cmd_t        cmd;
    logic [IDX_W-1:0]  scan_pos;
    logic              blank_phase;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_word;
    logic [FRAME_W-1:0] frame_calc;
    logic [IDX_W-1:0]  idx_clamped;

    // the held request moves on only when the result register has room
    assign out_free = !out_valid_reg || !out_stall;
    assign proceed  = req_valid_reg && out_free;
    assign in_stall = req_valid_reg && !out_free;
    assign req_load = in_valid && !in_stall;

    // indexes past the last digit fold onto the last digit
    assign idx_clamped = (digit_index > 8'(DIGIT_COUNT - 1)) ? LAST_IDX
                                                             : digit_index[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (req_load)
        begin
            req_valid_reg <= 1'b1;
        end
        else if (proceed)
        begin
            req_valid_reg <= 1'b0;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (req_load)
        begin
            func_reg <= func;
            idx_reg  <= idx_clamped;
            code_reg <= char_code;
        end
    end

    // command decode, store updates only fire when the request moves on
    always_comb
    begin
        cmd           = '0;
        cmd.idx       = idx_reg;
        cmd.glyph     = glyph_lookup(code_reg, limit_reg);
        is_scan       = 1'b0;
        is_show       = 1'b0;
        unique case (func_reg)
            FUNC_SCAN:      is_scan       = proceed;
            FUNC_WR_CHAR:   cmd.wr_char   = proceed;
            FUNC_SET_DP:    cmd.set_dp    = proceed;
            FUNC_CLR_DP:    cmd.clr_dp    = proceed;
            FUNC_SET_BLINK: cmd.set_blink = proceed;
            FUNC_CLR_BLINK: cmd.clr_blink = proceed;
            FUNC_CLR_ALL:   cmd.clr_all   = proceed;
            FUNC_CLR_DIGIT: cmd.clr_digit = proceed;
            FUNC_SHOW:      is_show       = proceed;
            default:        ;
        endcase
    end

    // single read port, scan position for ticks, addressed digit otherwise
    assign rd_addr = (func_reg == FUNC_SCAN) ? scan_pos : idx_reg;

    mvds_digit_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .rd_word (rd_word)
    );

    mvds_scan_ctrl u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (is_scan),
        .scan_pos    (scan_pos),
        .blank_phase (blank_phase)
    );

    // on scan ticks, a blinking digit in the dark half of the phase keeps only grid and dp
    always_comb
    begin
        frame_calc = rd_word[FRAME_W-1:0];
        if ((func_reg == FUNC_SCAN) && rd_word[BLINK_BIT] && blank_phase)
        begin
            frame_calc = rd_word[FRAME_W-1:0] & BLANK_KEEP;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (is_scan || is_show)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_scan || is_show)
        begin
            frame_reg <= frame_calc;
            shown_reg <= SHOWN_W'(rd_addr);
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame       = frame_reg;
    assign shown_digit = shown_reg;

endmodule
